### src/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int ADDR_WIDTH_DEF  = 32;

  localparam int DATA_W     = 8;
  localparam int IN_ADDR_W  = 32;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int PAT_WORDS  = 4;
  localparam int LEN_W      = 6;

  localparam logic [DATA_W-1:0] WILDCARD_BYTE = 8'h3F;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WC   = 3'd5;

  // Pattern configuration as seen by the matcher
  typedef struct packed {
    logic [PAT_WORDS-1:0][CFG_W-1:0] pat;
    logic [LEN_W-1:0]                len;
    logic                            wc;
  } pat_cfg_t;

endpackage

### src/wbps_matcher.sv
// ----------------------------------------------------------------------------
// wbps_matcher
// Aligned pattern/care registers and the parallel window compare.
// ----------------------------------------------------------------------------
module wbps_matcher #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
  localparam int FW = $clog2(MAX_PATTERN + 1)
) (
  input  logic                                         clk,
  input  wbps_pkg::pat_cfg_t                           cfg,
  input  logic [MAX_PATTERN-1:0][wbps_pkg::DATA_W-1:0] win,
  input  logic [FW-1:0]                                fresh_cnt,
  output logic                                         hit,
  output logic [FW-1:0]                                len_m1
);

  logic [FW-1:0]                                len_used;
  logic [FW-1:0]                                len_used_r;
  logic [MAX_PATTERN-1:0][wbps_pkg::DATA_W-1:0] apat_nxt;
  logic [MAX_PATTERN-1:0][wbps_pkg::DATA_W-1:0] apat_r;
  logic [MAX_PATTERN-1:0]                       care_nxt;
  logic [MAX_PATTERN-1:0]                       care_r;
  logic [MAX_PATTERN-1:0]                       pos_ok;

  // Clamp the programmed length into 1..MAX_PATTERN
  always_comb begin
    if (cfg.len == '0) begin
      len_used = FW'(1);
    end else if (cfg.len > wbps_pkg::LEN_W'(MAX_PATTERN)) begin
      len_used = FW'(MAX_PATTERN);
    end else begin
      len_used = cfg.len[FW-1:0];
    end
  end

  // Reverse the pattern so window entry j lines up with pattern byte len-1-j
  always_comb begin
    logic [4:0]                 idx;
    logic [wbps_pkg::DATA_W-1:0] pb;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      idx         = 5'(len_used - FW'(1) - FW'(j));
      pb          = cfg.pat[idx[4:3]][{idx[2:0], 3'b000} +: wbps_pkg::DATA_W];
      apat_nxt[j] = pb;
      care_nxt[j] = (FW'(j) < len_used) && !(cfg.wc && (pb == wbps_pkg::WILDCARD_BYTE));
    end
  end

  always_ff @(posedge clk) begin
    apat_r     <= apat_nxt;
    care_r     <= care_nxt;
    len_used_r <= len_used;
  end

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pos_ok[j] = !care_r[j] || (win[j] == apat_r[j]);
    end
    hit    = (&pos_ok) && (fresh_cnt >= len_used_r);
    len_m1 = len_used_r - FW'(1);
  end

endmodule

### src/wildcard_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Streams bytes through a sliding window and reports non-overlapping matches
// of a programmable wildcard pattern by their start address.
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock while the output is not stalled and
// reports a match from the result register once the byte that completes it
// has passed the input stage. It has two register stages (input stage, result
// stage) with the full window compare done in parallel between them. The
// input stage holds only when a result is waiting at a stalled output. A
// pattern byte of 0x3F matches any byte while the REG_WC bit is set. After a
// match, or after a byte flagged region_end, the window is emptied, so matches
// never overlap and never span regions. Program the configuration only while
// the scanner is idle.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
  parameter int ADDR_WIDTH  = wbps_pkg::ADDR_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbps_pkg::CFG_W-1:0]        cfg_data,
  // byte stream
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wbps_pkg::DATA_W-1:0]       in_data_byte,
  input  logic [wbps_pkg::IN_ADDR_W-1:0]    in_byte_address,
  input  logic                              in_region_end,
  // match results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wbps_pkg::IN_ADDR_W-1:0]    out_match_address
);

  localparam int FW = $clog2(MAX_PATTERN + 1);
  // start address wraps at the narrower of the address space and the port
  localparam int MW = (ADDR_WIDTH < wbps_pkg::IN_ADDR_W) ? ADDR_WIDTH : wbps_pkg::IN_ADDR_W;
  localparam logic [wbps_pkg::IN_ADDR_W-1:0] ADDR_MASK =
    {wbps_pkg::IN_ADDR_W{1'b1}} >> (wbps_pkg::IN_ADDR_W - MW);

  // configuration registers
  logic [wbps_pkg::PAT_WORDS-1:0][wbps_pkg::CFG_W-1:0] pat_r;
  logic [wbps_pkg::LEN_W-1:0]                          len_r;
  logic                                                wc_r;
  wbps_pkg::pat_cfg_t                                  pat_cfg;

  // input stage
  logic                              s1_valid_r;
  logic                              s1_valid_nxt;
  logic [wbps_pkg::DATA_W-1:0]       s1_byte_r;
  logic [wbps_pkg::IN_ADDR_W-1:0]    s1_addr_r;
  logic                              s1_end_r;
  logic                              s1_adv;
  logic                              in_xfer;

  // window state
  logic [MAX_PATTERN-1:0][wbps_pkg::DATA_W-1:0] win_r;
  logic [MAX_PATTERN-1:0][wbps_pkg::DATA_W-1:0] win_sh;
  logic [FW-1:0]                                fresh_r;
  logic [FW-1:0]                                fresh_inc;
  logic [FW-1:0]                                fresh_nxt;

  // compare results
  logic                              hit;
  logic [FW-1:0]                     len_m1;
  logic [wbps_pkg::IN_ADDR_W-1:0]    start_addr;

  // result stage
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [wbps_pkg::IN_ADDR_W-1:0]    out_addr_r;

  // --------------------------------------------------------------------------
  // Configuration: unknown indexes are dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      len_r <= wbps_pkg::LEN_W'(1);
      wc_r  <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wbps_pkg::REG_PAT0: pat_r[0] <= cfg_data;
        wbps_pkg::REG_PAT1: pat_r[1] <= cfg_data;
        wbps_pkg::REG_PAT2: pat_r[2] <= cfg_data;
        wbps_pkg::REG_PAT3: pat_r[3] <= cfg_data;
        wbps_pkg::REG_LEN:  len_r    <= cfg_data[wbps_pkg::LEN_W-1:0];
        wbps_pkg::REG_WC:   wc_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign pat_cfg = '{pat: pat_r, len: len_r, wc: wc_r};

  // --------------------------------------------------------------------------
  // Handshake: the input stage advances whenever the result stage is free or
  // being emptied; hold it only behind a stalled result.
  // --------------------------------------------------------------------------
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // capture the transfer payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_data_byte;
      s1_addr_r <= in_byte_address;
      s1_end_r  <= in_region_end;
    end
  end

  // --------------------------------------------------------------------------
  // Window: shift the staged byte in at entry 0 (newest)
  // --------------------------------------------------------------------------
  always_comb begin
    win_sh[0] = s1_byte_r;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_sh[i] = win_r[i-1];
    end
  end

  // fresh count saturates at the window depth
  assign fresh_inc = (fresh_r == FW'(MAX_PATTERN)) ? fresh_r : fresh_r + FW'(1);
  // empty the window after a match or at the end of a region
  assign fresh_nxt = (hit || s1_end_r) ? '0 : fresh_inc;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_r <= win_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= '0;
    end else if (s1_adv) begin
      fresh_r <= fresh_nxt;
    end
  end

  wbps_matcher #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_matcher (
    .clk       (clk),
    .cfg       (pat_cfg),
    .win       (win_sh),
    .fresh_cnt (fresh_inc),
    .hit       (hit),
    .len_m1    (len_m1)
  );

  // start address = address of the completing byte minus (length - 1)
  assign start_addr = (s1_addr_r - wbps_pkg::IN_ADDR_W'(len_m1)) & ADDR_MASK;

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_comb begin
    if (s1_adv && hit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && hit) begin
      out_addr_r <= start_addr;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_address = out_addr_r;

endmodule

### src/wbps_checker.sv
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level assertions for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
module wbps_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [wbps_pkg::IN_ADDR_W-1:0] out_match_address
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_address))
    else $error("stalled result changed");

  // reset empties both stages
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // input holds only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // a fresh result comes from an input transfer that passed the input stage before it
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching input transfer");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_match_address (out_match_address)
);

### dv/wildcard_byte_pattern_scanner_tb.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_tb
// Self-checking bench for the byte pattern scanner. It streams addressed bytes
// through the scanner and predicts every reported match start address. It
// runs a directed sequence first, then random regions under many pattern
// settings, with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wbps_pkg::*;

  // Indexes past the last register: writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  localparam int NUM_PHASES  = 12;
  localparam int PHASE_BYTES = 135;

  // Predicts match start addresses from the accepted byte stream and holds
  // them until the scanner reports them.
  class match_start_predictor;
    bit [CFG_W-1:0]     pat_words[PAT_WORDS];
    bit [LEN_W-1:0]     pat_len;
    bit                 wc_en;
    bit [DATA_W-1:0]    window[MAX_PATTERN_DEF];
    int unsigned        fresh;
    bit [IN_ADDR_W-1:0] expected_starts[$];
    int unsigned        fail_count;

    function new();
      foreach (pat_words[i]) pat_words[i] = '0;
      foreach (window[i]) window[i] = '0;
      pat_len    = 1;
      wc_en      = 1'b1;
      fresh      = 0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] value);
      case (idx)
        REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_words[idx] = value;
        REG_LEN: pat_len = value[LEN_W-1:0];
        REG_WC:  wc_en   = value[0];
        default: ;
      endcase
    endfunction

    // Zero acts as one, anything past the window acts as the full window.
    function int unsigned used_len();
      if (pat_len == 0) return 1;
      if (pat_len > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
      return pat_len;
    endfunction

    function bit [DATA_W-1:0] pat_byte(int unsigned k);
      return pat_words[k >> 3][(k & 7) * 8 +: 8];
    endfunction

    function void note_byte(bit [DATA_W-1:0] data, bit [IN_ADDR_W-1:0] addr, bit last);
      int unsigned len;
      bit hit;
      bit [DATA_W-1:0] p;
      for (int i = MAX_PATTERN_DEF - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = data;
      if (fresh < MAX_PATTERN_DEF) fresh++;
      len = used_len();
      hit = (fresh >= len);
      for (int unsigned k = 0; k < len; k++) begin
        p = pat_byte(k);
        if (!(wc_en && p == WILDCARD_BYTE) && p != window[len - 1 - k]) hit = 1'b0;
      end
      if (hit) begin
        expected_starts.insert(expected_starts.size(), addr - IN_ADDR_W'(len - 1));
        fresh = 0;
      end
      if (last) fresh = 0;
    endfunction

    function void check_match(bit [IN_ADDR_W-1:0] got);
      bit [IN_ADDR_W-1:0] want;
      if (expected_starts.size() == 0) begin
        $error("match_address: no match expected, actual %h", got);
        fail_count++;
      end else begin
        want = expected_starts.pop_front();
        if (got !== want) begin
          $error("match_address: expected %h, actual %h", want, got);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [DATA_W-1:0]    in_data_byte;
  logic [IN_ADDR_W-1:0] in_byte_address;
  logic                 in_region_end;
  logic                 out_valid;
  logic                 out_stall;
  logic [IN_ADDR_W-1:0] out_match_address;

  match_start_predictor sb;
  bit [IN_ADDR_W-1:0]   next_addr;
  bit                   quiet_tail;
  bit                   gappy;

  wildcard_byte_pattern_scanner i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_byte_address   (in_byte_address),
    .in_region_end     (in_region_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_match_address (out_match_address)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Check every result transfer against the oldest predicted start.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_match(out_match_address);
  end

  // Stall bursts separated by open stretches, some long;
  // drop all stalling once the quiet tail starts.
  initial begin
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (quiet_tail) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
        repeat (($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                             : $urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Present one byte, hold it until the transfer happens, then log it.
  // Valid stays high after the transfer so back-to-back bytes need no toggle.
  task automatic drive_byte(input bit [DATA_W-1:0] data, input bit [IN_ADDR_W-1:0] addr,
                            input bit last);
    if (!quiet_tail && gappy && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= data;
    in_byte_address <= addr;
    in_region_end   <= last;
    do @(posedge clk); while (in_stall);
    sb.note_byte(data, addr, last);
  endtask

  // Send at the running address; on a region end jump to a new base,
  // often just below the wrap point.
  task automatic emit(input bit [DATA_W-1:0] data, input bit last);
    drive_byte(data, next_addr, last);
    next_addr++;
    if (last) begin
      if ($urandom_range(0, 3) == 0) next_addr = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else next_addr = $urandom;
    end
  endtask

  // Lower valid and wait until every predicted match is out, then give the
  // two-stage pipe time to flush bytes that produce no match.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_starts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all registers, plus the two unused indexes with junk.
  task automatic set_config(input bit [CFG_W-1:0] p0, input bit [CFG_W-1:0] p1,
                            input bit [CFG_W-1:0] p2, input bit [CFG_W-1:0] p3,
                            input bit [LEN_W-1:0] len, input bit wc);
    bit [CFG_W-1:0] vals[8];
    logic [CFG_IDX_W-1:0] idx;
    vals[REG_PAT0]   = p0;
    vals[REG_PAT1]   = p1;
    vals[REG_PAT2]   = p2;
    vals[REG_PAT3]   = p3;
    vals[REG_LEN]    = CFG_W'(len);
    vals[REG_WC]     = CFG_W'(wc);
    vals[REG_SPARE6] = {$urandom, $urandom};
    vals[REG_SPARE7] = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) begin
      idx = CFG_IDX_W'(i);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(idx, vals[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Small alphabet so random streams hit patterns often.
  function automatic bit [DATA_W-1:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return WILDCARD_BYTE;
      1:       return 8'h00;
      2:       return 8'hFF;
      default: return 8'h41 + DATA_W'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic bit rand_last();
    return ($urandom_range(0, 59) == 0);
  endfunction

  // Send one copy of the pattern with random bytes under the wildcards;
  // now and then flip a bit in one byte to make a near miss.
  task automatic emit_instance();
    int unsigned n;
    int unsigned bad;
    bit [DATA_W-1:0] b;
    n   = sb.used_len();
    bad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : n;
    for (int unsigned k = 0; k < n; k++) begin
      b = sb.pat_byte(k);
      if (sb.wc_en && b == WILDCARD_BYTE) b = DATA_W'($urandom);
      if (k == bad) b = b ^ DATA_W'(1 << $urandom_range(0, 7));
      emit(b, rand_last());
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned lens[NUM_PHASES];
    bit [CFG_W-1:0] words[PAT_WORDS];
    bit [DATA_W-1:0] b;

    sb = new();
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= REG_PAT0;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    in_data_byte    <= '0;
    in_byte_address <= '0;
    in_region_end   <= 1'b0;
    quiet_tail      = 1'b0;
    gappy           = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset pattern: one exact byte 0x00. Hit at address zero and a
    // single-byte hit on a region end at the top address.
    next_addr = '0;
    emit(8'h00, 1'b0);
    emit(8'hFF, 1'b0);
    next_addr = 32'hFFFF_FFFF;
    drive_byte(8'h00, next_addr, 1'b1);

    // "?BCD" with wildcards on; unused pattern words at their extremes.
    wait_idle();
    set_config(64'h0000_0000_4443_423F, '1, '0, 64'h3F3F_3F3F_3F3F_3F3F, 6'd4, 1'b1);
    next_addr = 32'hFFFF_FFFE;                 // match straddles address zero
    emit(8'h11, 1'b0); emit(8'h42, 1'b0); emit(8'h43, 1'b0); emit(8'h44, 1'b0);
    emit(8'h00, 1'b0); emit(8'h42, 1'b1);       // region ends mid-pattern
    emit(8'h43, 1'b0); emit(8'h44, 1'b0);       // too few fresh bytes: no hit
    emit(8'h3F, 1'b0); emit(8'h42, 1'b0); emit(8'h43, 1'b0); emit(8'h44, 1'b1);
    emit(8'h41, 1'b0); emit(8'h42, 1'b0); emit(8'h43, 1'b0); emit(8'h44, 1'b0);
    emit(8'h43, 1'b0); emit(8'h44, 1'b0);       // tail after a hit must not reuse bytes

    // Same pattern, exact compare: 0x3F must be matched literally.
    wait_idle();
    set_config(64'h0000_0000_4443_423F, '0, '1, '0, 6'd4, 1'b0);
    emit(8'h3F, 1'b0); emit(8'h42, 1'b0); emit(8'h43, 1'b0); emit(8'h44, 1'b0);
    emit(8'h41, 1'b0); emit(8'h42, 1'b0); emit(8'h43, 1'b0); emit(8'h44, 1'b0);

    // Random phases: lengths cover zero, one, full window and past it.
    lens = '{0, 1, 2, 3, 5, 8, 32, 63, 40, 12, 33, 7};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      for (int w = 0; w < PAT_WORDS; w++) begin
        case (ph)
          1:       words[w] = 64'h3F3F_3F3F_3F3F_3F3F;
          2:       words[w] = '1;
          3:       words[w] = '0;
          default: begin
            for (int k = 0; k < 8; k++) words[w][k*8 +: 8] = pick_byte();
          end
        endcase
      end
      set_config(words[0], words[1], words[2], words[3], LEN_W'(lens[ph]), ph % 3 != 2);
      gappy      = ($urandom_range(0, 3) != 0);
      quiet_tail = (ph == NUM_PHASES - 1);
      next_addr  = $urandom;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        if ($urandom_range(0, 9) < 4) begin
          emit_instance();
          sent += sb.used_len();
        end else begin
          case ($urandom_range(0, 3))
            0, 1:    b = sb.pat_byte($urandom_range(0, MAX_PATTERN_DEF - 1));
            2:       b = pick_byte();
            default: b = DATA_W'($urandom);
          endcase
          emit(b, rand_last());
          sent++;
        end
      end
    end

    // Drain, bounded: anything still predicted afterwards is a miss.
    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && sb.expected_starts.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.expected_starts.size() != 0) begin
      $error("match_address: %0d expected matches never arrived, oldest %h",
             sb.expected_starts.size(), sb.expected_starts[0]);
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
